// ===== sv/phv_pkg.sv =====
// ----------------------------------------------------------------------------
// phv_pkg - shared types and constants for the pH conversion pipeline
// Register indexes, status codes, stage payload structs and fixed limits.
// ----------------------------------------------------------------------------
`default_nettype none

package phv_pkg;

	// configuration register indexes
	localparam logic [2:0] REG_CAL_PH_1   = 3'd0;
	localparam logic [2:0] REG_CAL_PH_2   = 3'd1;
	localparam logic [2:0] REG_CAL_PH_3   = 3'd2;
	localparam logic [2:0] REG_CAL_VOLT_1 = 3'd3;
	localparam logic [2:0] REG_CAL_VOLT_2 = 3'd4;
	localparam logic [2:0] REG_CAL_VOLT_3 = 3'd5;
	localparam logic [2:0] REG_CAL_TEMP   = 3'd6;

	// result status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_DEGEN = 2'd2;

	// limits and offsets
	localparam logic signed [23:0] VOLT_MAX = 24'sd2500000;
	localparam logic signed [23:0] VOLT_MIN = -24'sd2500000;
	localparam logic signed [16:0] KELVIN_CENTI = 17'sd27315;
	localparam logic [13:0] PH_MAX = 14'd14000;

	// reset values of the calibration registers
	localparam logic [13:0] RST_PH_1 = 14'd4000;
	localparam logic [13:0] RST_PH_2 = 14'd7000;
	localparam logic [13:0] RST_PH_3 = 14'd10000;
	localparam logic signed [22:0] RST_VOLT_1 = 23'sd177480;
	localparam logic signed [22:0] RST_VOLT_2 = 23'sd0;
	localparam logic signed [22:0] RST_VOLT_3 = -23'sd177480;
	localparam logic signed [14:0] RST_TEMP = 15'sd2500;

	// calibration register set
	typedef struct packed {
		logic [13:0]        p1;
		logic [13:0]        p2;
		logic [13:0]        p3;
		logic signed [22:0] v1;
		logic signed [22:0] v2;
		logic signed [22:0] v3;
		logic signed [14:0] tc;
	} cal_t;

	// fitted line terms, leaving the fit stages
	typedef struct packed {
		logic               vbad;
		logic signed [42:0] nslope;
		logic signed [32:0] dslope;
		logic [31:0]        a;      // sp * tk
		logic signed [43:0] b;      // (3V - sv) * tck
		logic [15:0]        tk;
	} fit_t;

	// rational pH = num / den, leaving the product stages
	typedef struct packed {
		logic               vbad;
		logic               degen;
		logic signed [75:0] num;
		logic [59:0]        den;
	} prod_t;

	// restoring division word between steps
	typedef struct packed {
		logic [1:0]  status;
		logic        zero;
		logic        over;
		logic [74:0] rem;
		logic [73:0] dsh;
		logic [13:0] q;
	} div_t;

endpackage

`default_nettype wire

// ===== sv/phv_fit.sv =====
// ----------------------------------------------------------------------------
// phv_fit - least-squares fit and temperature terms
// Three stages: point products, cross products, slope and temperature terms.
// ----------------------------------------------------------------------------
`default_nettype none

module phv_fit (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic signed [23:0] voltage_uv,
	input  wire logic signed [14:0] water_temp_centi_c,
	input  wire logic               temp_valid,
	input  wire phv_pkg::cal_t      cal,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output phv_pkg::fit_t           out
);

	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	// stage 1 registers
	logic               vbad_s1;
	logic [15:0]        tk_s1, tck_s1, sp_s1;
	logic signed [24:0] sv_s1;
	logic signed [37:0] pv1_s1, pv2_s1, pv3_s1;
	logic [27:0]        pp1_s1, pp2_s1, pp3_s1;
	logic signed [25:0] v3x_s1;

	// stage 2 registers
	logic               vbad_s2;
	logic [15:0]        tk_s2, tck_s2, sp_s2;
	logic signed [41:0] spv3_s2, spsv_s2;
	logic [31:0]        spp3_s2, spsp_s2;
	logic signed [26:0] dv_s2;

	// stage 1 logic
	logic signed [14:0] tsel;
	logic signed [16:0] tk_w, tck_w;
	logic signed [25:0] vx;

	assign tsel  = temp_valid ? water_temp_centi_c : cal.tc;
	assign tk_w  = {{2{tsel[14]}}, tsel} + phv_pkg::KELVIN_CENTI;
	assign tck_w = {{2{cal.tc[14]}}, cal.tc} + phv_pkg::KELVIN_CENTI;
	assign vx    = {{2{voltage_uv[23]}}, voltage_uv};

	// stage 2 logic
	logic signed [41:0] spv_x;
	logic [31:0]        spp_x;

	assign spv_x = {{4{pv1_s1[37]}}, pv1_s1} + {{4{pv2_s1[37]}}, pv2_s1}
		+ {{4{pv3_s1[37]}}, pv3_s1};
	assign spp_x = {4'b0, pp1_s1} + {4'b0, pp2_s1} + {4'b0, pp3_s1};

	// advance a stage when it is empty or the next one moves
	assign en3      = !v_s3 || out_ready;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// stage 1: range check, kelvin, sums and point products
	always_ff @(posedge clk) begin
		if (en1) begin
			vbad_s1 <= (voltage_uv < phv_pkg::VOLT_MIN) || (voltage_uv > phv_pkg::VOLT_MAX);
			tk_s1   <= tk_w[15:0];
			tck_s1  <= tck_w[15:0];
			sp_s1   <= {2'b0, cal.p1} + {2'b0, cal.p2} + {2'b0, cal.p3};
			sv_s1   <= {{2{cal.v1[22]}}, cal.v1} + {{2{cal.v2[22]}}, cal.v2}
				+ {{2{cal.v3[22]}}, cal.v3};
			pv1_s1  <= $signed({1'b0, cal.p1}) * cal.v1;
			pv2_s1  <= $signed({1'b0, cal.p2}) * cal.v2;
			pv3_s1  <= $signed({1'b0, cal.p3}) * cal.v3;
			pp1_s1  <= cal.p1 * cal.p1;
			pp2_s1  <= cal.p2 * cal.p2;
			pp3_s1  <= cal.p3 * cal.p3;
			v3x_s1  <= vx + (vx <<< 1);
		end
	end

	// stage 2: scaled sums and cross products
	always_ff @(posedge clk) begin
		if (en2) begin
			vbad_s2 <= vbad_s1;
			tk_s2   <= tk_s1;
			tck_s2  <= tck_s1;
			sp_s2   <= sp_s1;
			spv3_s2 <= spv_x + (spv_x <<< 1);
			spp3_s2 <= spp_x + (spp_x << 1);
			spsv_s2 <= $signed({1'b0, sp_s1}) * sv_s1;
			spsp_s2 <= sp_s1 * sp_s1;
			dv_s2   <= {v3x_s1[25], v3x_s1} - {{2{sv_s1[24]}}, sv_s1};
		end
	end

	// stage 3: slope terms and temperature-scaled parts
	always_ff @(posedge clk) begin
		if (en3) begin
			out.vbad   <= vbad_s2;
			out.nslope <= {spv3_s2[41], spv3_s2} - {spsv_s2[41], spsv_s2};
			out.dslope <= {1'b0, spp3_s2} - {1'b0, spsp_s2};
			out.a      <= sp_s2 * tk_s2;
			out.b      <= dv_s2 * $signed({1'b0, tck_s2});
			out.tk     <= tk_s2;
		end
	end

	assign out_valid = v_s3;

endmodule

`default_nettype wire

// ===== sv/phv_prod.sv =====
// ----------------------------------------------------------------------------
// phv_prod - wide numerator and denominator products
// Four stages: magnitudes, split partial products, recombine, signed sum.
// ----------------------------------------------------------------------------
`default_nettype none

module phv_prod (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire phv_pkg::fit_t in,
	output logic               out_valid,
	input  wire logic          out_ready,
	output phv_pkg::prod_t     out
);

	logic v_s4, v_s5, v_s6, v_s7;
	logic en4, en5, en6, en7;

	// stage 4 registers
	logic        vbad_s4, degen_s4, sgn_s4;
	logic [41:0] nmag_s4, bmag_s4;
	logic [31:0] dmag_s4, a_s4;
	logic [17:0] t3_s4;

	// stage 5 registers
	logic        vbad_s5, degen_s5, sgn_s5;
	logic [52:0] pa_lo_s5, pa_hi_s5, pb_lo_s5, pb_hi_s5;
	logic [38:0] pd_lo_s5, pd_hi_s5;

	// stage 6 registers
	logic        vbad_s6, degen_s6, sgn_s6;
	logic [73:0] pa_s6, pb_s6;
	logic [59:0] den_s6;

	logic [42:0] nabs;
	logic [43:0] babs;

	assign nabs = in.nslope[42] ? 43'(-in.nslope) : in.nslope;
	assign babs = in.b[43] ? 44'(-in.b) : in.b;

	// advance a stage when it is empty or the next one moves
	assign en7      = !v_s7 || out_ready;
	assign en6      = !v_s6 || en7;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign in_ready = en4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en4) v_s4 <= in_valid;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
			if (en7) v_s7 <= v_s6;
		end
	end

	// stage 4: magnitudes, sign of the correction term, degenerate fit
	always_ff @(posedge clk) begin
		if (en4) begin
			vbad_s4  <= in.vbad;
			degen_s4 <= (in.nslope == '0) || (in.dslope == '0);
			sgn_s4   <= in.nslope[42] ^ in.b[43];
			nmag_s4  <= nabs[41:0];
			bmag_s4  <= babs[41:0];
			dmag_s4  <= in.dslope[31:0];
			a_s4     <= in.a;
			t3_s4    <= {2'b0, in.tk} + {1'b0, in.tk, 1'b0};
		end
	end

	// stage 5: split partial products
	always_ff @(posedge clk) begin
		if (en5) begin
			vbad_s5  <= vbad_s4;
			degen_s5 <= degen_s4;
			sgn_s5   <= sgn_s4;
			pa_lo_s5 <= a_s4 * nmag_s4[20:0];
			pa_hi_s5 <= a_s4 * nmag_s4[41:21];
			pb_lo_s5 <= bmag_s4[20:0] * dmag_s4;
			pb_hi_s5 <= bmag_s4[41:21] * dmag_s4;
			pd_lo_s5 <= t3_s4 * nmag_s4[20:0];
			pd_hi_s5 <= t3_s4 * nmag_s4[41:21];
		end
	end

	// stage 6: recombine halves
	always_ff @(posedge clk) begin
		if (en6) begin
			vbad_s6  <= vbad_s5;
			degen_s6 <= degen_s5;
			sgn_s6   <= sgn_s5;
			pa_s6    <= {21'b0, pa_lo_s5} + {pa_hi_s5, 21'b0};
			pb_s6    <= {21'b0, pb_lo_s5} + {pb_hi_s5, 21'b0};
			den_s6   <= {21'b0, pd_lo_s5} + {pd_hi_s5, 21'b0};
		end
	end

	// stage 7: signed numerator
	always_ff @(posedge clk) begin
		if (en7) begin
			out.vbad  <= vbad_s6;
			out.degen <= degen_s6;
			out.num   <= sgn_s6 ? ({2'b0, pa_s6} - {2'b0, pb_s6})
				: ({2'b0, pa_s6} + {2'b0, pb_s6});
			out.den   <= den_s6;
		end
	end

	assign out_valid = v_s7;

endmodule

`default_nettype wire

// ===== sv/phv_div_step.sv =====
// ----------------------------------------------------------------------------
// phv_div_step - one restoring division step
// Compares the remainder with the shifted divisor and emits one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module phv_div_step (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire phv_pkg::div_t in,
	output logic              out_valid,
	input  wire logic         out_ready,
	output phv_pkg::div_t     out
);

	logic v_q;
	logic en;
	logic take;

	assign en       = !v_q || out_ready;
	assign in_ready = en;
	assign take     = in.rem >= {1'b0, in.dsh};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	// subtract when the divisor fits, shift the divisor down
	always_ff @(posedge clk) begin
		if (en) begin
			out.status <= in.status;
			out.zero   <= in.zero;
			out.over   <= in.over;
			out.rem    <= take ? (in.rem - {1'b0, in.dsh}) : in.rem;
			out.dsh    <= in.dsh >> 1;
			out.q      <= {in.q[12:0], take};
		end
	end

	assign out_valid = v_q;

endmodule

`default_nettype wire

// ===== sv/ph_from_electrode_voltage_unit.sv =====
// ----------------------------------------------------------------------------
// ph_from_electrode_voltage_unit - temperature compensated pH from voltage
// Converts an electrode voltage to milli-pH through a three point fit.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries one word per sample: tdata holds the voltage
//   in microvolts and the water temperature in 0.01 C, tuser flags the
//   temperature as valid (else the calibration temperature is used).
//   Output stream m_axis returns one word per sample in order: tdata holds
//   the pH in milli-pH, tuser the status (ok, voltage out of range, fit
//   degenerate). The cfg channel writes the seven calibration registers; it
//   is always ready and is to be used only while no sample is in flight.
//   Words pass through three fit stages, four product stages, one range stage,
//   fourteen restoring division steps (one quotient bit each) and the output
//   register. Throughput is one word per cycle while the receiver keeps up.
//   Each stage has its own valid bit and loads when empty or when the
//   stage after it moves, so a stalled receiver halts words only as far back
//   as the pipeline is full and bubbles are squeezed out; nothing is lost
//   or repeated. Reset empties the pipeline and loads the default
//   calibration (pH 4, 7, 10 at +177.48 mV, 0, -177.48 mV, 25.00 C).
// ----------------------------------------------------------------------------
`default_nettype none

module ph_from_electrode_voltage_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [39:0] s_axis_tdata,  // [23:0] voltage_uv, [38:24] water_temp_centi_c
	input  wire logic [0:0]  s_axis_tuser,  // [0] temp_valid
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,  // [13:0] ph_milli
	output logic [1:0]       m_axis_tuser,  // [1:0] status
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [22:0] cfg_data
);

	phv_pkg::cal_t  cal_q;
	phv_pkg::fit_t  fit;
	phv_pkg::prod_t prod;
	logic           fit_valid, fit_ready, prod_valid, prod_ready;

	// calibration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_q.p1 <= phv_pkg::RST_PH_1;
			cal_q.p2 <= phv_pkg::RST_PH_2;
			cal_q.p3 <= phv_pkg::RST_PH_3;
			cal_q.v1 <= phv_pkg::RST_VOLT_1;
			cal_q.v2 <= phv_pkg::RST_VOLT_2;
			cal_q.v3 <= phv_pkg::RST_VOLT_3;
			cal_q.tc <= phv_pkg::RST_TEMP;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				phv_pkg::REG_CAL_PH_1:   cal_q.p1 <= cfg_data[13:0];
				phv_pkg::REG_CAL_PH_2:   cal_q.p2 <= cfg_data[13:0];
				phv_pkg::REG_CAL_PH_3:   cal_q.p3 <= cfg_data[13:0];
				phv_pkg::REG_CAL_VOLT_1: cal_q.v1 <= cfg_data;
				phv_pkg::REG_CAL_VOLT_2: cal_q.v2 <= cfg_data;
				phv_pkg::REG_CAL_VOLT_3: cal_q.v3 <= cfg_data;
				phv_pkg::REG_CAL_TEMP:   cal_q.tc <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	phv_fit u_fit (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (s_axis_tvalid),
		.in_ready           (s_axis_tready),
		.voltage_uv         (s_axis_tdata[23:0]),
		.water_temp_centi_c (s_axis_tdata[38:24]),
		.temp_valid         (s_axis_tuser[0]),
		.cal                (cal_q),
		.out_valid          (fit_valid),
		.out_ready          (fit_ready),
		.out                (fit)
	);

	phv_prod u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fit_valid),
		.in_ready  (fit_ready),
		.in        (fit),
		.out_valid (prod_valid),
		.out_ready (prod_ready),
		.out       (prod)
	);

	// range stage: status, sign and clamp test ahead of the division
	phv_pkg::div_t div_s8;
	logic          v_s8, en8;
	logic          dv [0:14];
	logic          dr [0:14];
	phv_pkg::div_t dd [0:14];

	assign en8        = !v_s8 || dr[0];
	assign prod_ready = en8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en8) begin
			v_s8 <= prod_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en8) begin
			priority if (prod.vbad) begin
				div_s8.status <= phv_pkg::ST_RANGE;
			end else if (prod.degen) begin
				div_s8.status <= phv_pkg::ST_DEGEN;
			end else begin
				div_s8.status <= phv_pkg::ST_OK;
			end
			div_s8.zero <= prod.num[75];
			div_s8.over <= !prod.num[75] && (prod.num[74:0] >= {1'b0, prod.den, 14'b0});
			div_s8.rem  <= prod.num[74:0];
			div_s8.dsh  <= {1'b0, prod.den, 13'b0};
			div_s8.q    <= '0;
		end
	end

	assign dv[0] = v_s8;
	assign dd[0] = div_s8;

	// fourteen division steps, most significant quotient bit first
	for (genvar k = 0; k < 14; k++) begin : g_div
		phv_div_step u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv[k]),
			.in_ready  (dr[k]),
			.in        (dd[k]),
			.out_valid (dv[k+1]),
			.out_ready (dr[k+1]),
			.out       (dd[k+1])
		);
	end

	// output register: clamp and zero on error
	logic [13:0] ph_w;
	logic        v_out_q;
	logic [13:0] ph_q;
	logic [1:0]  status_q;

	assign dr[14] = !v_out_q || m_axis_tready;

	always_comb begin
		if (dd[14].status != phv_pkg::ST_OK || dd[14].zero) begin
			ph_w = '0;
		end else if (dd[14].over || dd[14].q > phv_pkg::PH_MAX) begin
			ph_w = phv_pkg::PH_MAX;
		end else begin
			ph_w = dd[14].q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out_q <= 1'b0;
		end else if (dr[14]) begin
			v_out_q <= dv[14];
		end
	end

	always_ff @(posedge clk) begin
		if (dr[14]) begin
			ph_q     <= ph_w;
			status_q <= dd[14].status;
		end
	end

	assign m_axis_tvalid = v_out_q;
	assign m_axis_tdata  = {2'b0, ph_q};
	assign m_axis_tuser  = status_q;

	// result never exceeds the pH ceiling
	a_ph_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (ph_q <= phv_pkg::PH_MAX))
		else $error("pH result above ceiling");

	// an error status always carries a zero pH
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status_q != phv_pkg::ST_OK) |-> (ph_q == '0))
		else $error("nonzero pH with error status");

	// the input side only stalls behind a held output word
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
		else $error("input stalled without output backpressure");

	// a word leaving the range stage with a clamp has a nonnegative numerator
	a_over_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && div_s8.over) |-> !div_s8.zero)
		else $error("clamp flagged on negative numerator");

endmodule

`default_nettype wire

// ===== bench/ph_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ph_checker - scoreboard for the pH conversion unit
// Watches the sample, result and register channels, keeps its own copy of the
// calibration and predicts the pH word of every accepted sample. It compares
// each result word in order and counts failures.
// ----------------------------------------------------------------------------

module ph_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,
	input  logic [0:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [15:0] m_axis_tdata,
	input  logic [1:0]  m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [22:0] cfg_data,
	output int          fail_count,
	output int          pending,
	output int          results_seen,
	output int          ok_seen
);

	typedef struct packed {
		logic [13:0] ph_milli;
		logic [1:0]  status;
	} ph_word_t;

	ph_word_t       ph_expected_q[$];
	phv_pkg::cal_t  cal;

	// pH of one sample under the current calibration
	function automatic ph_word_t predict_ph(logic signed [23:0] volt,
			logic signed [14:0] temp, logic tvalid);
		longint p1, p2, p3, v1, v2, v3, tc, sp, sv, spv, spp, nsl, dsl, tck, tk;
		logic signed [127:0] num, den, q;
		ph_word_t r;
		r.ph_milli = '0;
		if (volt > phv_pkg::VOLT_MAX || volt < phv_pkg::VOLT_MIN) begin
			r.status = phv_pkg::ST_RANGE;
			return r;
		end
		p1 = cal.p1; p2 = cal.p2; p3 = cal.p3;
		v1 = cal.v1; v2 = cal.v2; v3 = cal.v3; tc = cal.tc;
		sp  = p1 + p2 + p3;
		sv  = v1 + v2 + v3;
		spv = p1 * v1 + p2 * v2 + p3 * v3;
		spp = p1 * p1 + p2 * p2 + p3 * p3;
		nsl = 3 * spv - sp * sv;
		dsl = 3 * spp - sp * sp;
		if (nsl == 0 || dsl == 0) begin
			r.status = phv_pkg::ST_DEGEN;
			return r;
		end
		tck = tc + longint'(phv_pkg::KELVIN_CENTI);
		tk  = tvalid ? longint'(temp) + longint'(phv_pkg::KELVIN_CENTI) : tck;
		num = 128'(sp * tk) * 128'(nsl) + 128'((3 * longint'(volt) - sv) * tck) * 128'(dsl);
		den = 128'(3 * tk) * 128'(nsl < 0 ? -nsl : nsl);
		if (nsl < 0)
			num = -num;
		r.status = phv_pkg::ST_OK;
		if (num >= 0) begin
			q = num / den;
			r.ph_milli = (q > phv_pkg::PH_MAX) ? phv_pkg::PH_MAX : q[13:0];
		end
		return r;
	endfunction

	assign pending = ph_expected_q.size();

	always @(posedge clk or negedge arst_n) begin
		ph_word_t got, want;
		if (!arst_n) begin
			cal <= '{phv_pkg::RST_PH_1, phv_pkg::RST_PH_2, phv_pkg::RST_PH_3,
				phv_pkg::RST_VOLT_1, phv_pkg::RST_VOLT_2, phv_pkg::RST_VOLT_3,
				phv_pkg::RST_TEMP};
			ph_expected_q.delete();
			fail_count   <= 0;
			results_seen <= 0;
			ok_seen      <= 0;
		end else begin
			// track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					phv_pkg::REG_CAL_PH_1:   cal.p1 <= cfg_data[13:0];
					phv_pkg::REG_CAL_PH_2:   cal.p2 <= cfg_data[13:0];
					phv_pkg::REG_CAL_PH_3:   cal.p3 <= cfg_data[13:0];
					phv_pkg::REG_CAL_VOLT_1: cal.v1 <= cfg_data;
					phv_pkg::REG_CAL_VOLT_2: cal.v2 <= cfg_data;
					phv_pkg::REG_CAL_VOLT_3: cal.v3 <= cfg_data;
					phv_pkg::REG_CAL_TEMP:   cal.tc <= cfg_data[14:0];
					default: ;
				endcase
			end
			// predict each accepted sample word
			if (s_axis_tvalid && s_axis_tready)
				ph_expected_q.push_back(predict_ph(s_axis_tdata[23:0], s_axis_tdata[38:24],
					s_axis_tuser[0]));
			// compare each result word with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got.ph_milli = m_axis_tdata[13:0];
				got.status   = m_axis_tuser;
				results_seen <= results_seen + 1;
				if (ph_expected_q.size() == 0) begin
					$error("result word with no sample pending: ph_milli %0d status %0d",
						got.ph_milli, got.status);
					fail_count <= fail_count + 1;
				end else begin
					want = ph_expected_q.pop_front();
					if (want.status == phv_pkg::ST_OK)
						ok_seen <= ok_seen + 1;
					if (got.ph_milli != want.ph_milli || got.status != want.status ||
							m_axis_tdata[15:14] != 2'b00) begin
						if (got.ph_milli != want.ph_milli)
							$error("ph_milli: expected %0d, actual %0d", want.ph_milli,
								got.ph_milli);
						if (got.status != want.status)
							$error("status: expected %0d, actual %0d", want.status,
								got.status);
						if (m_axis_tdata[15:14] != 2'b00)
							$error("tdata pad: expected 0, actual %0d", m_axis_tdata[15:14]);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

// ===== bench/tb_ph_from_electrode_voltage_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ph_from_electrode_voltage_unit - testbench for the pH conversion unit
// Runs several calibration settings with random samples, the first two also
// with directed ones, under random idling on both streams; checker judges all.
// ----------------------------------------------------------------------------

module tb_ph_from_electrode_voltage_unit;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int DRAIN_CYCLES = 30;
	localparam int STALL_LIMIT  = 5000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;
	logic [0:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [22:0] cfg_data = '0;

	int  fail_count, pending, results_seen, ok_seen;
	int  sink_hold;
	int  stall_cycles;
	bit  gaps_on = 1'b1;
	int  samples_sent;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	ph_from_electrode_voltage_unit i_dut (.*);

	ph_checker i_checker (.*);

	// receiver: random stall bursts, none when gaps are off
	always @(posedge clk) begin
		if (!gaps_on) begin
			m_axis_tready <= 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_axis_tready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			sink_hold <= $urandom_range(1, 14) - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready) || !arst_n)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles > STALL_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// wait at a negedge until ready is seen high, then take the edge
	task automatic wait_sample_taken();
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
	endtask

	// send one sample word; valid stays high unless a gap follows
	task automatic send_sample(logic signed [23:0] volt, logic [14:0] temp, logic tvalid);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {1'b0, temp, volt};
		s_axis_tuser  <= tvalid;
		wait_sample_taken();
		samples_sent++;
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
	endtask

	// drop the sample valid, then hold until the pipeline is empty
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [22:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		while (!cfg_ready) @(negedge clk);
		@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_cal(int p1, int p2, int p3, int v1, int v2, int v3, int tc);
		write_reg(phv_pkg::REG_CAL_PH_1, 23'(p1));
		write_reg(phv_pkg::REG_CAL_PH_2, 23'(p2));
		write_reg(phv_pkg::REG_CAL_PH_3, 23'(p3));
		write_reg(phv_pkg::REG_CAL_VOLT_1, 23'(v1));
		write_reg(phv_pkg::REG_CAL_VOLT_2, 23'(v2));
		write_reg(phv_pkg::REG_CAL_VOLT_3, 23'(v3));
		write_reg(phv_pkg::REG_CAL_TEMP, 23'(tc));
	endtask

	// random sample: mostly in range near the fit, some anywhere
	task automatic random_samples(int count);
		logic signed [23:0] volt;
		logic [14:0] temp;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0:       volt = 24'($urandom);
				1:       volt = $urandom_range(0, 1) ? 24'(2500000 + $urandom_range(0, 2))
					: 24'(-2500000 - $urandom_range(0, 2));
				2, 3:    volt = 24'($signed($urandom_range(0, 5000000)) - 2500000);
				default: volt = 24'($signed($urandom_range(0, 800000)) - 400000);
			endcase
			temp = ($urandom_range(0, 7) == 0) ? 15'($urandom)
				: 15'($signed($urandom_range(0, 12000)) - 2000);
			send_sample(volt, temp, $urandom_range(0, 3) != 0);
		end
	endtask

	task automatic directed_samples();
		send_sample(24'sd0, 15'sd2500, 1'b1);
		send_sample(24'sd2500000, 15'sd2500, 1'b1);
		send_sample(-24'sd2500000, 15'sd2500, 1'b1);
		send_sample(24'sd2500001, 15'sd2500, 1'b1);
		send_sample(-24'sd2500001, 15'sd2500, 1'b1);
		send_sample(24'sh7FFFFF, 15'sd0, 1'b1);
		send_sample(24'sh800000, 15'sd0, 1'b1);
		send_sample(24'sd100000, -15'sd2000, 1'b1);
		send_sample(24'sd100000, 15'sd10000, 1'b1);
		send_sample(24'sd100000, 15'sd10000, 1'b0);
		send_sample(-24'sd300000, 15'sh4000, 1'b1);
		send_sample(24'sd300000, 15'sh3FFF, 1'b1);
		send_sample(24'sd900000, 15'sd2500, 1'b0);
		send_sample(-24'sd900000, 15'sd2500, 1'b0);
	endtask

	initial begin
		samples_sent = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset calibration
		directed_samples();
		random_samples(100);
		drain();

		// extremes: full pH span, wide voltages, hottest water
		write_cal(0, 14000, 7000, 2500000, -2500000, 0, 10000);
		write_reg(REG_UNUSED, 23'h7FFFFF);
		directed_samples();
		random_samples(80);
		drain();

		// coldest calibration, inverted slope
		write_cal(4000, 7000, 10000, -177480, 0, 177480, -2000);
		random_samples(80);
		drain();

		// equal buffers: zero denominator
		write_cal(7000, 7000, 7000, 100, 200, 300, 2500);
		random_samples(20);
		drain();

		// equal voltages: zero slope
		write_cal(4000, 7000, 10000, 5000, 5000, 5000, 2500);
		random_samples(20);
		drain();

		// raw register bits beyond the nominal ranges
		write_cal(16383, 0, 8191, 23'h3FFFFF, 23'h400000, 23'h155555, 15'h7FFF);
		random_samples(40);
		drain();

		// random calibrations, last one with no idling
		for (int k = 0; k < 4; k++) begin
			if (k == 3)
				gaps_on = 1'b0;
			write_cal($urandom_range(0, 14000), $urandom_range(0, 14000),
				$urandom_range(0, 14000), $signed($urandom_range(0, 5000000)) - 2500000,
				$signed($urandom_range(0, 5000000)) - 2500000,
				$signed($urandom_range(0, 5000000)) - 2500000,
				$signed($urandom_range(0, 12000)) - 2000);
			random_samples(60);
			drain();
		end

		$display("Covered %0d samples over ten calibrations, %0d results (%0d in range).",
			samples_sent, results_seen, ok_seen);
		$display("Settings included reset, extremes, degenerate fits and raw register bits.");
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
